// ===== rtl/lbse_pkg.sv =====
`default_nettype none
package lbse_pkg;

  // Default text store depth; the top level may override it (1 to 63).
  localparam int MAX_CHARS = 40;

  localparam int LEN_W    = 6;
  localparam int WEIGHT_W = 6;
  localparam int C128_MOD = 103;

  // Configuration register indexes.
  localparam logic REG_SYMBOLOGY  = 1'b0;
  localparam logic REG_WIDE_WIDTH = 1'b1;

  localparam logic [6:0] C128_START_B = 7'd104;
  localparam logic [6:0] C128_START_C = 7'd105;
  localparam logic [6:0] C128_STOP    = 7'd106;
  // Check sums start at the start value reduced mod 103.
  localparam logic [6:0] C128_SEED_B  = 7'd1;
  localparam logic [6:0] C128_SEED_C  = 7'd2;

  localparam logic [3:0] CNT_C39      = 4'd9;
  localparam logic [3:0] CNT_C128     = 4'd6;
  localparam logic [3:0] CNT_C128_END = 4'd7;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_SPACE = 8'h20;

  // Start and stop character '*': one bit per element, first element on the left.
  localparam logic [8:0] C39_FRAME = 9'b010010100;

  typedef struct packed {
    logic [8:0][2:0] elem;
    logic [3:0]      count;
    logic            gap;
    logic            last;
  } sym_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             digits;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_FETCH,
    ST_LOAD,
    ST_ACC,
    ST_CHECK,
    ST_STOP
  } back_state_t;

  typedef logic [6:0] mod_tab_t [256];

  // Residue of (index * 64) mod 103, built at elaboration.
  function automatic mod_tab_t build_mod_tab();
    mod_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 7'((i * 64) % C128_MOD);
    end
    return t;
  endfunction

  localparam mod_tab_t MOD_TAB = build_mod_tab();

  // x mod 103 for a 14-bit x: the upper bits go through the table, then one
  // conditional subtract.
  function automatic logic [6:0] mod103(input logic [13:0] x);
    logic [7:0] r;
    r = {1'b0, MOD_TAB[x[13:6]]} + {2'b00, x[5:0]};
    if (r >= 8'(C128_MOD)) begin
      r = r - 8'(C128_MOD);
    end
    return r[6:0];
  endfunction

  // Code 39 lookup: bit 9 is set when the byte is in the character set,
  // bits 8:0 give the wide elements, first element in bit 8.
  function automatic logic [9:0] c39_lookup(input logic [7:0] b);
    logic [7:0] c;
    logic [9:0] r;
    c = b;
    if (b inside {[8'h61:8'h7A]}) begin
      c = b - 8'h20;
    end
    case (c)
      "0":     r = {1'b1, 9'b000110100};
      "1":     r = {1'b1, 9'b100100001};
      "2":     r = {1'b1, 9'b001100001};
      "3":     r = {1'b1, 9'b101100000};
      "4":     r = {1'b1, 9'b000110001};
      "5":     r = {1'b1, 9'b100110000};
      "6":     r = {1'b1, 9'b001110000};
      "7":     r = {1'b1, 9'b000100101};
      "8":     r = {1'b1, 9'b100100100};
      "9":     r = {1'b1, 9'b001100100};
      "A":     r = {1'b1, 9'b100001001};
      "B":     r = {1'b1, 9'b001001001};
      "C":     r = {1'b1, 9'b101001000};
      "D":     r = {1'b1, 9'b000011001};
      "E":     r = {1'b1, 9'b100011000};
      "F":     r = {1'b1, 9'b001011000};
      "G":     r = {1'b1, 9'b000001101};
      "H":     r = {1'b1, 9'b100001100};
      "I":     r = {1'b1, 9'b001001100};
      "J":     r = {1'b1, 9'b000011100};
      "K":     r = {1'b1, 9'b100000011};
      "L":     r = {1'b1, 9'b001000011};
      "M":     r = {1'b1, 9'b101000010};
      "N":     r = {1'b1, 9'b000010011};
      "O":     r = {1'b1, 9'b100010010};
      "P":     r = {1'b1, 9'b001010010};
      "Q":     r = {1'b1, 9'b000000111};
      "R":     r = {1'b1, 9'b100000110};
      "S":     r = {1'b1, 9'b001000110};
      "T":     r = {1'b1, 9'b000010110};
      "U":     r = {1'b1, 9'b110000001};
      "V":     r = {1'b1, 9'b011000001};
      "W":     r = {1'b1, 9'b111000000};
      "X":     r = {1'b1, 9'b010010001};
      "Y":     r = {1'b1, 9'b110010000};
      "Z":     r = {1'b1, 9'b011010000};
      "-":     r = {1'b1, 9'b010000101};
      ".":     r = {1'b1, 9'b110000100};
      " ":     r = {1'b1, 9'b011000100};
      "$":     r = {1'b1, 9'b010101000};
      "/":     r = {1'b1, 9'b010100010};
      "+":     r = {1'b1, 9'b010001010};
      "%":     r = {1'b1, 9'b000101010};
      default: r = 10'd0;
    endcase
    return r;
  endfunction

  // Code 128 element widths, one nibble each, first element in the top nibble.
  // Six-element symbols leave the last nibble zero.
  function automatic logic [27:0] c128_pattern(input logic [6:0] v);
    logic [27:0] p;
    case (v)
      7'd0:   p = 28'h2122220;  7'd1:   p = 28'h2221220;
      7'd2:   p = 28'h2222210;  7'd3:   p = 28'h1212230;
      7'd4:   p = 28'h1213220;  7'd5:   p = 28'h1312220;
      7'd6:   p = 28'h1222130;  7'd7:   p = 28'h1223120;
      7'd8:   p = 28'h1322120;  7'd9:   p = 28'h2212130;
      7'd10:  p = 28'h2213120;  7'd11:  p = 28'h2312120;
      7'd12:  p = 28'h1122320;  7'd13:  p = 28'h1221320;
      7'd14:  p = 28'h1222310;  7'd15:  p = 28'h1132220;
      7'd16:  p = 28'h1231220;  7'd17:  p = 28'h1232210;
      7'd18:  p = 28'h2232110;  7'd19:  p = 28'h2211320;
      7'd20:  p = 28'h2212310;  7'd21:  p = 28'h2132120;
      7'd22:  p = 28'h2231120;  7'd23:  p = 28'h3121310;
      7'd24:  p = 28'h3112220;  7'd25:  p = 28'h3211220;
      7'd26:  p = 28'h3212210;  7'd27:  p = 28'h3122120;
      7'd28:  p = 28'h3221120;  7'd29:  p = 28'h3222110;
      7'd30:  p = 28'h2121230;  7'd31:  p = 28'h2123210;
      7'd32:  p = 28'h2321210;  7'd33:  p = 28'h1113230;
      7'd34:  p = 28'h1311230;  7'd35:  p = 28'h1313210;
      7'd36:  p = 28'h1123130;  7'd37:  p = 28'h1321130;
      7'd38:  p = 28'h1323110;  7'd39:  p = 28'h2113130;
      7'd40:  p = 28'h2311130;  7'd41:  p = 28'h2313110;
      7'd42:  p = 28'h1121330;  7'd43:  p = 28'h1123310;
      7'd44:  p = 28'h1321310;  7'd45:  p = 28'h1131230;
      7'd46:  p = 28'h1133210;  7'd47:  p = 28'h1331210;
      7'd48:  p = 28'h3131210;  7'd49:  p = 28'h2113310;
      7'd50:  p = 28'h2311310;  7'd51:  p = 28'h2131130;
      7'd52:  p = 28'h2133110;  7'd53:  p = 28'h2131310;
      7'd54:  p = 28'h3111230;  7'd55:  p = 28'h3113210;
      7'd56:  p = 28'h3311210;  7'd57:  p = 28'h3121130;
      7'd58:  p = 28'h3123110;  7'd59:  p = 28'h3321110;
      7'd60:  p = 28'h3141110;  7'd61:  p = 28'h2214110;
      7'd62:  p = 28'h4311110;  7'd63:  p = 28'h1112240;
      7'd64:  p = 28'h1114220;  7'd65:  p = 28'h1211240;
      7'd66:  p = 28'h1214210;  7'd67:  p = 28'h1411220;
      7'd68:  p = 28'h1412210;  7'd69:  p = 28'h1122140;
      7'd70:  p = 28'h1124120;  7'd71:  p = 28'h1221140;
      7'd72:  p = 28'h1224110;  7'd73:  p = 28'h1421120;
      7'd74:  p = 28'h1422110;  7'd75:  p = 28'h2412110;
      7'd76:  p = 28'h2211140;  7'd77:  p = 28'h4131110;
      7'd78:  p = 28'h2411120;  7'd79:  p = 28'h1341110;
      7'd80:  p = 28'h1112420;  7'd81:  p = 28'h1211420;
      7'd82:  p = 28'h1212410;  7'd83:  p = 28'h1142120;
      7'd84:  p = 28'h1241120;  7'd85:  p = 28'h1242110;
      7'd86:  p = 28'h4112120;  7'd87:  p = 28'h4211120;
      7'd88:  p = 28'h4212110;  7'd89:  p = 28'h2121410;
      7'd90:  p = 28'h2141210;  7'd91:  p = 28'h4121210;
      7'd92:  p = 28'h1111430;  7'd93:  p = 28'h1113410;
      7'd94:  p = 28'h1311410;  7'd95:  p = 28'h1141130;
      7'd96:  p = 28'h1143110;  7'd97:  p = 28'h4111130;
      7'd98:  p = 28'h4113110;  7'd99:  p = 28'h1131410;
      7'd100: p = 28'h1141310;  7'd101: p = 28'h3111410;
      7'd102: p = 28'h4111310;  7'd103: p = 28'h2114120;
      7'd104: p = 28'h2112140;  7'd105: p = 28'h2112320;
      7'd106: p = 28'h2331112;
      default: p = 28'h2122220;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lbse_ram.sv =====
`default_nettype none
module lbse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 40,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/lbse_front.sv =====
`default_nettype none
module lbse_front #(
  parameter int MAX_CHARS = lbse_pkg::MAX_CHARS,
  localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            req_type,
  input  wire logic [7:0]      char_code,
  input  wire logic            hold,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic [7:0]           wr_data,
  output logic                 job_push,
  output lbse_pkg::job_t       job
);

  logic [lbse_pkg::LEN_W-1:0] text_length;
  logic                       digits_only;
  logic                       accept;
  logic                       room;

  // Loads touch the text store, so nothing is taken while the back end reads it.
  assign in_ready = !hold;
  assign accept   = in_valid && in_ready;
  assign room     = text_length < lbse_pkg::LEN_W'(MAX_CHARS);

  assign wr_en    = accept && !req_type && room;
  assign wr_addr  = text_length[AW-1:0];
  assign wr_data  = char_code;

  assign job_push   = accept && req_type && (text_length != '0);
  assign job.len    = text_length;
  assign job.digits = digits_only;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_length <= '0;
      digits_only <= 1'b1;
    end else if (accept) begin
      if (req_type) begin
        text_length <= '0;
        digits_only <= 1'b1;
      end else if (room) begin
        text_length <= text_length + 1'b1;
        if (!(char_code inside {[8'h30:8'h39]})) begin
          digits_only <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lbse_queue.sv =====
`default_nettype none
module lbse_queue #(
  parameter int WIDTH = 7
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  output logic                  pop_valid,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slots [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full      = count[1];
  assign pop_valid = count != 2'd0;
  assign pop_data  = slots[rptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= !wptr;
      end
      if (do_pop) begin
        rptr <= !rptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lbse_back.sv =====
`default_nettype none
module lbse_back #(
  parameter int MAX_CHARS = lbse_pkg::MAX_CHARS,
  localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            job_valid,
  input  wire lbse_pkg::job_t  job,
  output logic                 job_pop,
  input  wire logic            symbology,
  input  wire logic [1:0]      wide_width,
  output logic [AW-1:0]        rd_addr,
  input  wire logic [7:0]      rd_data,
  output logic                 busy,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output lbse_pkg::sym_t       out_sym
);

  localparam int LW = lbse_pkg::LEN_W;
  localparam int WW = lbse_pkg::WEIGHT_W;

  lbse_pkg::back_state_t state, state_next;

  logic [LW-1:0] len, len_next;
  logic [LW-1:0] pos, pos_next;
  logic          mode_c39, mode_c39_next;
  logic          mode_pair, mode_pair_next;
  logic          half, half_next;
  logic [7:0]    hi_byte, hi_byte_next;
  logic [WW-1:0] weight, weight_next;
  logic [6:0]    acc, acc_next;
  logic [12:0]   prod, prod_next;

  logic            emit;
  lbse_pkg::sym_t  emit_sym;
  logic            slot_free;
  logic [2:0]      wide;
  logic [9:0]      c39_hit;
  logic [3:0]      dig_hi;
  logic [3:0]      dig_lo;
  logic [6:0]      pair_val;
  logic [6:0]      text_val;
  logic [6:0]      data_val;
  logic [LW-1:0]   pos_inc;
  logic            start_pair;

  function automatic lbse_pkg::sym_t c39_sym(input logic [8:0] pat, input logic [2:0] w,
                                            input logic gap);
    lbse_pkg::sym_t s;
    for (int i = 0; i < 9; i++) begin
      s.elem[i] = pat[8 - i] ? w : 3'd1;
    end
    s.count = lbse_pkg::CNT_C39;
    s.gap   = gap;
    s.last  = 1'b0;
    return s;
  endfunction

  function automatic lbse_pkg::sym_t c128_sym(input logic [6:0] v);
    lbse_pkg::sym_t s;
    logic [27:0]    p;
    p = lbse_pkg::c128_pattern(v);
    for (int i = 0; i < 7; i++) begin
      s.elem[i] = p[4 * (6 - i) +: 3];
    end
    s.elem[7] = 3'd0;
    s.elem[8] = 3'd0;
    s.count   = (v == lbse_pkg::C128_STOP) ? lbse_pkg::CNT_C128_END : lbse_pkg::CNT_C128;
    s.gap     = 1'b0;
    s.last    = 1'b0;
    return s;
  endfunction

  assign slot_free = !out_valid || out_ready;
  assign rd_addr   = pos[AW-1:0];
  assign busy      = state != lbse_pkg::ST_IDLE;
  assign wide      = (wide_width < 2'd2) ? 3'd2 : {1'b0, wide_width};
  assign c39_hit   = lbse_pkg::c39_lookup(rd_data);
  assign pos_inc   = pos + 1'b1;

  // Digit pair value: tens digit times ten as shift-and-add.
  assign dig_hi   = 4'(hi_byte - lbse_pkg::ASCII_ZERO);
  assign dig_lo   = 4'(rd_data - lbse_pkg::ASCII_ZERO);
  assign pair_val = 7'({dig_hi, 3'b000} + {2'b00, dig_hi, 1'b0} + {3'b000, dig_lo});
  assign text_val = (rd_data >= lbse_pkg::ASCII_SPACE && !rd_data[7]) ?
                    7'(rd_data - lbse_pkg::ASCII_SPACE) : 7'd0;
  assign data_val = mode_pair ? pair_val : text_val;

  assign start_pair = symbology && job.digits && !job.len[0];

  always_comb begin
    state_next     = state;
    len_next       = len;
    pos_next       = pos;
    mode_c39_next  = mode_c39;
    mode_pair_next = mode_pair;
    half_next      = half;
    hi_byte_next   = hi_byte;
    weight_next    = weight;
    acc_next       = acc;
    prod_next      = prod;
    job_pop        = 1'b0;
    emit           = 1'b0;
    emit_sym       = '0;
    case (state)
      lbse_pkg::ST_IDLE: begin
        if (job_valid) begin
          job_pop        = 1'b1;
          len_next       = job.len;
          pos_next       = '0;
          half_next      = 1'b0;
          weight_next    = WW'(1);
          mode_c39_next  = !symbology;
          mode_pair_next = start_pair;
          acc_next       = start_pair ? lbse_pkg::C128_SEED_C : lbse_pkg::C128_SEED_B;
          state_next     = lbse_pkg::ST_START;
        end
      end
      lbse_pkg::ST_START: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_sym   = mode_c39 ? c39_sym(lbse_pkg::C39_FRAME, wide, 1'b0) :
                       c128_sym(mode_pair ? lbse_pkg::C128_START_C : lbse_pkg::C128_START_B);
          state_next = lbse_pkg::ST_FETCH;
        end
      end
      lbse_pkg::ST_FETCH: begin
        state_next = lbse_pkg::ST_LOAD;
      end
      lbse_pkg::ST_LOAD: begin
        if (mode_c39) begin
          if (!c39_hit[9] || slot_free) begin
            emit       = c39_hit[9];
            emit_sym   = c39_sym(c39_hit[8:0], wide, 1'b1);
            pos_next   = pos_inc;
            state_next = (pos_inc == len) ? lbse_pkg::ST_STOP : lbse_pkg::ST_FETCH;
          end
        end else if (mode_pair && !half) begin
          hi_byte_next = rd_data;
          half_next    = 1'b1;
          pos_next     = pos_inc;
          state_next   = lbse_pkg::ST_FETCH;
        end else if (slot_free) begin
          emit        = 1'b1;
          emit_sym    = c128_sym(data_val);
          prod_next   = data_val * weight;
          weight_next = weight + 1'b1;
          half_next   = 1'b0;
          pos_next    = pos_inc;
          state_next  = lbse_pkg::ST_ACC;
        end
      end
      lbse_pkg::ST_ACC: begin
        acc_next   = lbse_pkg::mod103({7'd0, acc} + {1'b0, prod});
        state_next = (pos == len) ? lbse_pkg::ST_CHECK : lbse_pkg::ST_FETCH;
      end
      lbse_pkg::ST_CHECK: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_sym   = c128_sym(acc);
          state_next = lbse_pkg::ST_STOP;
        end
      end
      lbse_pkg::ST_STOP: begin
        if (slot_free) begin
          emit          = 1'b1;
          emit_sym      = mode_c39 ? c39_sym(lbse_pkg::C39_FRAME, wide, 1'b1) :
                          c128_sym(lbse_pkg::C128_STOP);
          emit_sym.last = 1'b1;
          state_next    = lbse_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lbse_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lbse_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    len       <= len_next;
    pos       <= pos_next;
    mode_c39  <= mode_c39_next;
    mode_pair <= mode_pair_next;
    half      <= half_next;
    hi_byte   <= hi_byte_next;
    weight    <= weight_next;
    acc       <= acc_next;
    prod      <= prod_next;
    if (emit) begin
      out_sym <= emit_sym;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/linear_barcode_symbol_encoder.sv =====
`default_nettype none
// Channel   Handshake              Payload
// input     in_valid / in_ready    req_type, char_code
// output    out_valid / out_ready  elem_width_1..9, element_count, gap_before, last_symbol
// config    cfg_we                 cfg_index, cfg_data
//
// A finish hands its job to the back end through the queue. Each Code 39 byte, skipped
// or not, is read from the store, then looked up; each Code 128 data symbol is read,
// looked up, then added into the check sum; each digit pair reads both bytes first.
// Start, check and stop emit one symbol each. Reset is synchronous and clears the text
// length and sequencer; no store clearing. Input stalls while a job waits or runs; the
// output register holds a symbol under back-pressure and the sequencer waits on it.
module linear_barcode_symbol_encoder #(
  parameter int MAX_CHARS = lbse_pkg::MAX_CHARS
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       req_type,
  input  wire logic [7:0] char_code,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      elem_width_1,
  output logic [2:0]      elem_width_2,
  output logic [2:0]      elem_width_3,
  output logic [2:0]      elem_width_4,
  output logic [2:0]      elem_width_5,
  output logic [2:0]      elem_width_6,
  output logic [2:0]      elem_width_7,
  output logic [2:0]      elem_width_8,
  output logic [2:0]      elem_width_9,
  output logic [3:0]      element_count,
  output logic            gap_before,
  output logic            last_symbol,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [1:0] cfg_data
);

  localparam int AW    = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int JOB_W = $bits(lbse_pkg::job_t);

  logic           symbology;
  logic [1:0]     wide_width;

  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [7:0]     wr_data;
  logic [AW-1:0]  rd_addr;
  logic [7:0]     rd_data;

  logic           job_push;
  lbse_pkg::job_t job_in;
  lbse_pkg::job_t job_out;
  logic           q_full;
  logic           q_valid;
  logic           job_pop;
  logic           back_busy;
  lbse_pkg::sym_t out_sym;

  // Configuration registers; they are meant to be written only while the block is idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      symbology  <= 1'b0;
      wide_width <= 2'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        lbse_pkg::REG_SYMBOLOGY:  symbology  <= cfg_data[0];
        lbse_pkg::REG_WIDE_WIDTH: wide_width <= cfg_data;
        default:                  symbology  <= symbology;
      endcase
    end
  end

  // Front end: appends text bytes to the store and turns a finish into a job.
  lbse_front #(.MAX_CHARS(MAX_CHARS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .char_code(char_code),
    .hold     (back_busy || q_valid || q_full),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .job_push (job_push),
    .job      (job_in)
  );

  lbse_ram #(.WIDTH(8), .DEPTH(MAX_CHARS)) u_text (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // Job queue between the two halves.
  lbse_queue #(.WIDTH(JOB_W)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_data(job_in),
    .full     (q_full),
    .pop_valid(q_valid),
    .pop      (job_pop),
    .pop_data (job_out)
  );

  // Back end: walks the stored text and emits one symbol at a time.
  lbse_back #(.MAX_CHARS(MAX_CHARS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job       (job_out),
    .job_pop   (job_pop),
    .symbology (symbology),
    .wide_width(wide_width),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .busy      (back_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_sym   (out_sym)
  );

  assign elem_width_1  = out_sym.elem[0];
  assign elem_width_2  = out_sym.elem[1];
  assign elem_width_3  = out_sym.elem[2];
  assign elem_width_4  = out_sym.elem[3];
  assign elem_width_5  = out_sym.elem[4];
  assign elem_width_6  = out_sym.elem[5];
  assign elem_width_7  = out_sym.elem[6];
  assign elem_width_8  = out_sym.elem[7];
  assign elem_width_9  = out_sym.elem[8];
  assign element_count = out_sym.count;
  assign gap_before    = out_sym.gap;
  assign last_symbol   = out_sym.last;

endmodule
`default_nettype wire
